[design/bps_pkg.sv]
package bps_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int IW  = $clog2(MAX_SAMPLES);
    localparam int CW  = $clog2(MAX_SAMPLES + 1);
    localparam int VW  = 31;
    localparam int FW  = 39;
    localparam int TW  = VW + IW;
    localparam int AW  = 2 * VW + IW;
    localparam int PW  = AW + CW;
    localparam int XW  = 2 * CW + 2 * VW - 2;
    localparam int DW  = XW + 16;
    localparam int SW  = 2 * VW + 14;
    localparam int DCW = $clog2(DW + 1);
    localparam int SCW = $clog2(SW / 2 + 1);

    typedef struct packed {
        logic load;
        logic div_avg;
        logic div_var;
        logic mean;
        logic rank_ld;
        logic rank_x;
        logic rank_sw;
        logic rank_upd;
        logic var_sw;
        logic prod;
        logic sub;
        logic sqrt_go;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
        logic i_last;
        logic j_last;
    } t_stat;

endpackage

[design/bps_ctrl.sv]
module bps_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic          i_last,
    input  bps_pkg::t_stat i_stat,
    output logic          o_busy,
    output bps_pkg::t_cmd  o_cmd
);
    import bps_pkg::*;

    typedef enum logic [19:0] {
        S_IDLE   = 20'h00001,
        S_DIVA   = 20'h00002,
        S_DIVA_W = 20'h00004,
        S_MEAN   = 20'h00008,
        S_RK_LD  = 20'h00010,
        S_RK_X   = 20'h00020,
        S_RK_SW  = 20'h00040,
        S_RK_END = 20'h00080,
        S_RK_UPD = 20'h00100,
        S_VR_SW  = 20'h00200,
        S_VR_D1  = 20'h00400,
        S_VR_D2  = 20'h00800,
        S_VR_D3  = 20'h01000,
        S_PROD   = 20'h02000,
        S_SUB    = 20'h04000,
        S_DIVV   = 20'h08000,
        S_DIVV_W = 20'h10000,
        S_SQ     = 20'h20000,
        S_SQ_W   = 20'h40000,
        S_EMIT   = 20'h80000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_accept && i_last) n_state = S_DIVA;
            S_DIVA:   n_state = S_DIVA_W;
            S_DIVA_W: if (i_stat.div_done) n_state = S_MEAN;
            S_MEAN:   n_state = S_RK_LD;
            S_RK_LD:  n_state = S_RK_X;
            S_RK_X:   n_state = S_RK_SW;
            S_RK_SW:  if (i_stat.j_last) n_state = S_RK_END;
            S_RK_END: n_state = S_RK_UPD;
            S_RK_UPD: n_state = i_stat.i_last ? S_VR_SW : S_RK_LD;
            S_VR_SW:  if (i_stat.j_last) n_state = S_VR_D1;
            S_VR_D1:  n_state = S_VR_D2;
            S_VR_D2:  n_state = S_VR_D3;
            S_VR_D3:  n_state = S_PROD;
            S_PROD:   n_state = S_SUB;
            S_SUB:    n_state = S_DIVV;
            S_DIVV:   n_state = S_DIVV_W;
            S_DIVV_W: if (i_stat.div_done) n_state = S_SQ;
            S_SQ:     n_state = S_SQ_W;
            S_SQ_W:   if (i_stat.sqrt_done) n_state = S_EMIT;
            S_EMIT:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_cmd.load     = i_accept;
    assign o_cmd.div_avg  = (r_state == S_DIVA);
    assign o_cmd.div_var  = (r_state == S_DIVV);
    assign o_cmd.mean     = (r_state == S_MEAN);
    assign o_cmd.rank_ld  = (r_state == S_RK_LD);
    assign o_cmd.rank_x   = (r_state == S_RK_X);
    assign o_cmd.rank_sw  = (r_state == S_RK_SW);
    assign o_cmd.rank_upd = (r_state == S_RK_UPD);
    assign o_cmd.var_sw   = (r_state == S_VR_SW);
    assign o_cmd.prod     = (r_state == S_PROD);
    assign o_cmd.sub      = (r_state == S_SUB);
    assign o_cmd.sqrt_go  = (r_state == S_SQ);
    assign o_cmd.emit     = (r_state == S_EMIT);

endmodule

[design/bps_dp.sv]
module bps_dp (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  bps_pkg::t_cmd            i_cmd,
    input  logic [bps_pkg::VW-1:0]   i_value,
    output bps_pkg::t_stat           o_stat,
    output logic                     o_valid,
    output logic [10:0]              o_sample_count,
    output logic [bps_pkg::VW-1:0]   o_smallest,
    output logic [bps_pkg::VW-1:0]   o_first_quartile,
    output logic [bps_pkg::VW-1:0]   o_middle_value,
    output logic [bps_pkg::VW-1:0]   o_third_quartile,
    output logic [bps_pkg::VW-1:0]   o_largest,
    output logic [bps_pkg::VW-1:0]   o_quartile_spread,
    output logic [bps_pkg::VW-1:0]   o_lower_fence,
    output logic [bps_pkg::VW-1:0]   o_upper_fence,
    output logic [bps_pkg::FW-1:0]   o_average_fixed,
    output logic [bps_pkg::FW-1:0]   o_deviation_fixed,
    output logic                     o_overflowed
);
    import bps_pkg::*;

    logic [VW-1:0] mem [MAX_SAMPLES];
    logic [VW-1:0] r_rd;
    logic [IW-1:0] rd_addr;

    logic [CW-1:0] r_cnt;
    logic [TW-1:0] r_tot;
    logic          r_drop;

    logic [IW-1:0] r_i, r_j;
    logic [VW-1:0] r_xi;
    logic [CW-1:0] r_lt, r_le;
    logic          r_v;
    logic [VW-1:0] r_mn, r_q1, r_md, r_q3, r_mx;

    logic [VW-1:0]   r_mb;
    logic [CW-1:0]   r_rem;
    logic [2*CW-1:0] r_nsq;
    logic [FW-1:0]   r_avg;

    logic            r_v1, r_v2, r_v3;
    logic [VW-1:0]   r_d;
    logic [2*VW-1:0] r_sq;
    logic [AW-1:0]   r_acc;
    logic [PW-1:0]   r_prod;
    logic [2*CW-1:0] r_rsq;
    logic [XW-1:0]   r_t;

    logic [DW-1:0]   r_dq;
    logic [2*CW:0]   r_drem;
    logic [2*CW-1:0] r_dd;
    logic [DCW-1:0]  r_dcnt;
    logic [2*CW:0]   d_sh;
    logic            d_ge;

    logic [SW-1:0]   r_sn, r_sr, r_sb;
    logic [SCW-1:0]  r_scnt;
    logic [SW-1:0]   s_t;

    logic [CW+1:0]   k1, k2, k3, k4, lt_x, le_x;
    logic [VW+2:0]   iqr_x, lo2, hi2;
    logic [VW-1:0]   iqr, lo, hi;
    logic [VW-1:0]   mean_q;
    logic [PW-1:0]   diff;

    assign rd_addr = i_cmd.rank_ld ? r_i : r_j;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (r_cnt < CW'(MAX_SAMPLES))) begin
            mem[r_cnt[IW-1:0]] <= i_value;
        end
        r_rd <= mem[rd_addr];
    end

    assign o_stat.j_last    = ({1'b0, r_j} == CW'(r_cnt - 1'b1));
    assign o_stat.i_last    = ({1'b0, r_i} == CW'(r_cnt - 1'b1));
    assign o_stat.div_done  = (r_dcnt == '0);
    assign o_stat.sqrt_done = (r_scnt == '0);

    assign k1   = (CW+2)'(r_cnt >> 2);
    assign k2   = (CW+2)'(r_cnt >> 1);
    assign k3   = (CW+2)'(((CW+2)'(r_cnt) * 3) >> 2);
    assign k4   = (CW+2)'(r_cnt) - 1'b1;
    assign lt_x = (CW+2)'(r_lt);
    assign le_x = (CW+2)'(r_le);

    assign mean_q = r_dq[VW+7:8];
    assign diff   = r_prod - PW'(r_rsq);

    assign d_sh = {r_drem[2*CW-1:0], r_dq[DW-1]};
    assign d_ge = (d_sh >= {1'b0, r_dd});
    assign s_t  = r_sr + r_sb;

    assign iqr_x = (VW+3)'(r_q3) - (VW+3)'(r_q1);
    assign iqr   = iqr_x[VW-1:0];
    assign lo2   = ((VW+3)'(r_q1) << 1) - (iqr_x * 3);
    assign hi2   = ((VW+3)'(r_q3) << 1) + (iqr_x * 3);
    always_comb begin
        lo = r_mn;
        if (!lo2[VW+2] && (lo2[VW+1:1] >= (VW+1)'(r_mn))) lo = lo2[VW:1];
        hi = r_mx;
        if (hi2[VW+2:1] < (VW+2)'(r_mx)) hi = hi2[VW:1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_tot   <= '0;
            r_drop  <= 1'b0;
            r_v     <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_dcnt  <= '0;
            r_scnt  <= '0;
            r_i     <= '0;
            r_j     <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.emit;
            r_v     <= i_cmd.rank_sw;
            r_v1    <= i_cmd.var_sw;
            r_v2    <= r_v1;
            r_v3    <= r_v2;

            if (i_cmd.load) begin
                if (r_cnt < CW'(MAX_SAMPLES)) begin
                    r_cnt <= r_cnt + 1'b1;
                    r_tot <= r_tot + TW'(i_value);
                end else begin
                    r_drop <= 1'b1;
                end
            end
            if (i_cmd.emit) begin
                r_cnt  <= '0;
                r_tot  <= '0;
                r_drop <= 1'b0;
            end

            if (i_cmd.mean) begin
                r_i <= '0;
                r_j <= '0;
            end
            if (i_cmd.rank_sw || i_cmd.var_sw) r_j <= r_j + 1'b1;
            if (i_cmd.rank_upd) begin
                r_i <= r_i + 1'b1;
                r_j <= '0;
            end

            if (i_cmd.div_avg || i_cmd.div_var) begin
                r_dcnt <= DCW'(DW);
            end else if (r_dcnt != '0) begin
                r_dcnt <= r_dcnt - 1'b1;
            end

            if (i_cmd.sqrt_go) begin
                r_scnt <= SCW'(SW / 2);
            end else if (r_scnt != '0) begin
                r_scnt <= r_scnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_avg) begin
            r_dq   <= DW'({r_tot, 8'b0});
            r_dd   <= (2*CW)'(r_cnt);
            r_drem <= '0;
        end else if (i_cmd.div_var) begin
            r_dq   <= {r_t, 16'b0};
            r_dd   <= r_nsq;
            r_drem <= '0;
        end else if (r_dcnt != '0) begin
            r_drem <= d_ge ? (d_sh - {1'b0, r_dd}) : d_sh;
            r_dq   <= {r_dq[DW-2:0], d_ge};
        end

        if (i_cmd.mean) begin
            r_avg <= r_dq[FW-1:0];
            r_mb  <= mean_q;
            r_rem <= CW'(r_tot - TW'(mean_q * r_cnt));
            r_nsq <= r_cnt * r_cnt;
            r_lt  <= '0;
            r_le  <= '0;
            r_acc <= '0;
        end

        if (i_cmd.rank_x) r_xi <= r_rd;
        if (r_v) begin
            if (r_rd < r_xi)  r_lt <= r_lt + 1'b1;
            if (r_rd <= r_xi) r_le <= r_le + 1'b1;
        end
        if (i_cmd.rank_upd) begin
            if (lt_x == '0)                   r_mn <= r_xi;
            if (lt_x <= k1 && k1 < le_x)      r_q1 <= r_xi;
            if (lt_x <= k2 && k2 < le_x)      r_md <= r_xi;
            if (lt_x <= k3 && k3 < le_x)      r_q3 <= r_xi;
            if (lt_x <= k4 && k4 < le_x)      r_mx <= r_xi;
            r_lt <= '0;
            r_le <= '0;
        end

        if (r_v1) r_d <= (r_rd >= r_mb) ? (r_rd - r_mb) : (r_mb - r_rd);
        if (r_v2) r_sq <= r_d * r_d;
        if (r_v3) r_acc <= r_acc + AW'(r_sq);

        if (i_cmd.prod) begin
            r_prod <= r_acc * r_cnt;
            r_rsq  <= r_rem * r_rem;
        end
        if (i_cmd.sub) r_t <= diff[XW-1:0];

        if (i_cmd.sqrt_go) begin
            r_sn <= r_dq[SW-1:0];
            r_sr <= '0;
            r_sb <= SW'(1) << (SW - 2);
        end else if (r_scnt != '0) begin
            if (r_sn >= s_t) begin
                r_sn <= r_sn - s_t;
                r_sr <= (r_sr >> 1) + r_sb;
            end else begin
                r_sr <= r_sr >> 1;
            end
            r_sb <= r_sb >> 2;
        end

        if (i_cmd.emit) begin
            o_sample_count    <= 11'(r_cnt);
            o_smallest        <= r_mn;
            o_first_quartile  <= r_q1;
            o_middle_value    <= r_md;
            o_third_quartile  <= r_q3;
            o_largest         <= r_mx;
            o_quartile_spread <= iqr;
            o_lower_fence     <= lo;
            o_upper_fence     <= hi;
            o_average_fixed   <= r_avg;
            o_deviation_fixed <= r_sr[FW-1:0];
            o_overflowed      <= r_drop;
        end
    end

endmodule

[design/box_plot_summary_statistics.sv]
// Box plot summary statistics.
// Request channel: drive i_value and i_last with start high; a request is
// taken at a rising edge where start is high and busy is low. Samples load
// one per cycle into a 1024-entry store; samples beyond capacity are dropped
// and flagged in o_overflowed.
// A request with i_last closes the set. busy then stays high while the set
// is processed. The block first runs a restoring division for the mean
// (98 quotient bits) and then takes the mean step. It ranks the store with
// one store read per cycle through the single read port. It sums and scales
// the squared deviations, runs a second division, takes a square root
// (38 result bits) and then emits the result.
// One set is processed at a time.
// The result shows for exactly one cycle with o_valid high; the receiver
// cannot stall it. busy drops in the cycle the result shows, so the next
// set may start loading at once.
// Reset is synchronous, active low, and empties the set; the store itself
// is not cleared.
module box_plot_summary_statistics (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [bps_pkg::VW-1:0] i_value,
    input  logic                   i_last,
    output logic                   o_valid,
    output logic [10:0]            o_sample_count,
    output logic [bps_pkg::VW-1:0] o_smallest,
    output logic [bps_pkg::VW-1:0] o_first_quartile,
    output logic [bps_pkg::VW-1:0] o_middle_value,
    output logic [bps_pkg::VW-1:0] o_third_quartile,
    output logic [bps_pkg::VW-1:0] o_largest,
    output logic [bps_pkg::VW-1:0] o_quartile_spread,
    output logic [bps_pkg::VW-1:0] o_lower_fence,
    output logic [bps_pkg::VW-1:0] o_upper_fence,
    output logic [bps_pkg::FW-1:0] o_average_fixed,
    output logic [bps_pkg::FW-1:0] o_deviation_fixed,
    output logic                   o_overflowed
);
    import bps_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  accept;

    assign accept = start && !busy;

    bps_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_last   (i_last),
        .i_stat   (stat),
        .o_busy   (busy),
        .o_cmd    (cmd)
    );

    bps_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_value           (i_value),
        .o_stat            (stat),
        .o_valid           (o_valid),
        .o_sample_count    (o_sample_count),
        .o_smallest        (o_smallest),
        .o_first_quartile  (o_first_quartile),
        .o_middle_value    (o_middle_value),
        .o_third_quartile  (o_third_quartile),
        .o_largest         (o_largest),
        .o_quartile_spread (o_quartile_spread),
        .o_lower_fence     (o_lower_fence),
        .o_upper_fence     (o_upper_fence),
        .o_average_fixed   (o_average_fixed),
        .o_deviation_fixed (o_deviation_fixed),
        .o_overflowed      (o_overflowed)
    );

`ifndef ASSERT_OFF
    a_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than one cycle");

    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_smallest <= o_first_quartile) && (o_first_quartile <= o_middle_value)
                 && (o_middle_value <= o_third_quartile) && (o_third_quartile <= o_largest))
        else $error("order statistics out of order");

    a_fence: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_lower_fence >= o_smallest) && (o_upper_fence <= o_largest))
        else $error("fence outside sample range");
`endif

endmodule
